// File: rtl/ucher_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the uniform cubic Hermite evaluator.
// No dependencies; imported by ucher_locate, ucher_horner and the top level.
package ucher_pkg;

    // default sizes for the top level parameters
    localparam int KNOT_DEPTH_DEF    = 128;
    localparam int FRACTION_BITS_DEF = 16;

    // fixed field widths
    localparam int VALUE_W  = 24;
    localparam int INDEX_W  = 7;
    localparam int KNOTS_W  = 8;
    localparam int RESULT_W = 32;

    // coefficient and Horner accumulator widths (c2 needs 9x a knot value)
    localparam int COEF_W = VALUE_W + 4;
    localparam int ACC_W  = VALUE_W + 6;

    localparam logic [KNOTS_W-1:0] NUM_KNOTS_RESET = 8'd2;

    // request codes
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } ucher_cmd_t;

    // control travelling alongside an evaluation
    typedef struct packed {
        logic valid;
        logic last;
    } ucher_side_t;

endpackage

// File: rtl/ucher_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucher_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ucher_locate.sv
`timescale 1ns / 1ps
// Position scaling: splits u * intervals into knot index and fraction t.
// Depends on ucher_pkg.
module ucher_locate #(
    parameter int KNOT_DEPTH    = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ucher_pkg::ucher_side_t            side_in,
    input  logic [ucher_pkg::KNOTS_W-1:0]     num_knots,
    input  logic [FRACTION_BITS:0]            position,
    output ucher_pkg::ucher_side_t            side_out,
    output logic [$clog2(KNOT_DEPTH)-1:0]     k_out,
    output logic [FRACTION_BITS:0]            t_out
);

    import ucher_pkg::*;

    localparam int KW = $clog2(KNOT_DEPTH);
    localparam int NW = $clog2(KNOT_DEPTH + 1);
    localparam int SW = FRACTION_BITS + 1 + KW;
    localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [NW-1:0]            knots;
    logic [KW-1:0]            intervals;
    logic [FRACTION_BITS:0]   u;
    logic [SW-1:0]            scaled;
    logic [KW:0]              k_raw;
    logic [KW-1:0]            k_next;
    logic [FRACTION_BITS:0]   t_next;
    ucher_side_t              side_reg;
    logic [KW-1:0]            k_reg;
    logic [FRACTION_BITS:0]   t_reg;

    // clamp knot count, clamp u, scale and split
    always_comb
    begin
        if (num_knots < KNOTS_W'(2))
        begin
            knots = NW'(2);
        end
        else if (32'(num_knots) > KNOT_DEPTH)
        begin
            knots = NW'(KNOT_DEPTH);
        end
        else
        begin
            knots = NW'(num_knots);
        end
        intervals = KW'(knots - NW'(1));

        u      = (position > ONE) ? ONE : position;
        scaled = SW'(u) * SW'(intervals);
        k_raw  = scaled[SW-1:FRACTION_BITS];

        // u at one lands on the last interval with t = 1.0
        if (k_raw >= {1'b0, intervals})
        begin
            k_next = intervals - KW'(1);
            t_next = ONE;
        end
        else
        begin
            k_next = KW'(k_raw);
            t_next = {1'b0, scaled[FRACTION_BITS-1:0]};
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        t_reg <= t_next;
    end

    assign side_out = side_reg;
    assign k_out    = k_reg;
    assign t_out    = t_reg;

endmodule

// File: rtl/ucher_horner.sv
`timescale 1ns / 1ps
// One Horner step: acc * t, rounded half up by the fraction width, plus c.
// Depends on ucher_pkg.
module ucher_horner #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ucher_pkg::ucher_side_t               side_in,
    input  logic signed [ucher_pkg::ACC_W-1:0]   acc_in,
    input  logic [FRACTION_BITS:0]               t_in,
    input  logic signed [ucher_pkg::ACC_W-1:0]   c_in,
    output ucher_pkg::ucher_side_t               side_out,
    output logic signed [ucher_pkg::ACC_W-1:0]   acc_out,
    output logic [FRACTION_BITS:0]               t_out
);

    import ucher_pkg::*;

    localparam int PW = ACC_W + FRACTION_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_rnd;
    logic signed [ACC_W-1:0] acc_next;
    ucher_side_t             side_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [FRACTION_BITS:0]  t_reg;

    // multiply, round, shift (floor), add the next coefficient
    always_comb
    begin
        prod     = PW'(acc_in) * PW'($signed({1'b0, t_in}));
        prod_rnd = prod + HALF;
        acc_next = ACC_W'(prod_rnd >>> FRACTION_BITS) + c_in;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        t_reg   <= t_in;
    end

    assign side_out = side_reg;
    assign acc_out  = acc_reg;
    assign t_out    = t_reg;

endmodule

// File: rtl/uniform_cubic_hermite_eval.sv
`timescale 1ns / 1ps
// Uniform cubic Hermite spline evaluator: top level, knot banks, coefficients, output.
// Depends on ucher_pkg, ucher_ram, ucher_locate, ucher_horner.
// Path: request register, locate, bank read, coefficients, Horner steps and the output register.
// Throughput: one request per cycle; knots k and k+1 come from even/odd banks, one read each.
// Reset clears the pipeline valid bits and sets num_knots to 2; knot tables are
// undefined until loaded. busy stays low: the receiver cannot stall results.
module uniform_cubic_hermite_eval #(
    parameter int KNOT_DEPTH    = ucher_pkg::KNOT_DEPTH_DEF,
    parameter int FRACTION_BITS = ucher_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   cmd,
    input  logic [ucher_pkg::INDEX_W-1:0]          knot_index,
    input  logic signed [ucher_pkg::VALUE_W-1:0]   knot_value,
    input  logic signed [ucher_pkg::VALUE_W-1:0]   knot_slope,
    input  logic [FRACTION_BITS:0]                 position,
    input  logic                                   last_query,
    // configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ucher_pkg::KNOTS_W-1:0]          cfg_data,
    // results
    output logic                                   result_valid,
    output logic signed [ucher_pkg::RESULT_W-1:0]  spline_value,
    output logic                                   saturated,
    output logic                                   last_result
);

    import ucher_pkg::*;

    localparam int KW         = $clog2(KNOT_DEPTH);
    localparam int BANK_DEPTH = (KNOT_DEPTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WORD_W     = 2 * VALUE_W;
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // configuration register
    logic [KNOTS_W-1:0] num_knots_reg;

    // stage 1: captured request
    logic                        s1_valid_reg;
    logic                        s1_cmd_reg;
    logic [INDEX_W-1:0]          s1_idx_reg;
    logic [WORD_W-1:0]           s1_word_reg;
    logic [FRACTION_BITS:0]      s1_pos_reg;
    logic                        s1_last_reg;
    ucher_side_t                 s1_side;

    // stage 2: located evaluation, pending load
    ucher_side_t                 s2_side;
    logic [KW-1:0]               s2_k;
    logic [FRACTION_BITS:0]      s2_t;
    logic                        s2_we_reg;
    logic [INDEX_W-1:0]          s2_widx_reg;
    logic [WORD_W-1:0]           s2_wdata_reg;
    logic [KW:0]                 k_plus;
    logic [BANK_AW-1:0]          even_raddr;
    logic [BANK_AW-1:0]          odd_raddr;
    logic [BANK_AW-1:0]          bank_waddr;

    // stage 3: knot words out of the banks
    logic [WORD_W-1:0]           even_rdata;
    logic [WORD_W-1:0]           odd_rdata;
    ucher_side_t                 s3_side_reg;
    logic [FRACTION_BITS:0]      s3_t_reg;
    logic                        s3_odd_reg;
    logic signed [VALUE_W-1:0]   p0, m0, p1, m1;
    logic signed [COEF_W-1:0]    p0x, m0x, p1x, m1x;
    logic signed [COEF_W-1:0]    c2_next, c3_next;

    // stage 4: coefficients
    ucher_side_t                 s4_side_reg;
    logic [FRACTION_BITS:0]      s4_t_reg;
    logic signed [COEF_W-1:0]    s4_c0_reg, s4_c1_reg, s4_c2_reg, s4_c3_reg;

    // Horner stages
    ucher_side_t                 h1_side, h2_side, h3_side;
    logic signed [ACC_W-1:0]     h1_acc, h2_acc, h3_acc;
    logic [FRACTION_BITS:0]      h1_t, h2_t, h3_t;
    logic signed [COEF_W-1:0]    s5_c1_reg, s5_c0_reg, s6_c0_reg;

    // output stage
    logic signed [63:0]          acc_wide;
    logic signed [RESULT_W-1:0]  value_next;
    logic                        sat_next;
    logic                        result_valid_reg;
    logic signed [RESULT_W-1:0]  spline_value_reg;
    logic                        saturated_reg;
    logic                        last_result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_knots_reg <= NUM_KNOTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_knots_reg <= cfg_data;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_we_reg        <= 1'b0;
            s3_side_reg      <= '0;
            s4_side_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= start && !busy;
            s2_we_reg        <= s1_valid_reg && (s1_cmd_reg == CMD_LOAD)
                                && (32'(s1_idx_reg) < KNOT_DEPTH);
            s3_side_reg      <= s2_side;
            s4_side_reg      <= s3_side_reg;
            result_valid_reg <= h3_side.valid;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= cmd;
        s1_idx_reg  <= knot_index;
        s1_word_reg <= {knot_value, knot_slope};
        s1_pos_reg  <= position;
        s1_last_reg <= last_query;
    end

    assign s1_side.valid = s1_valid_reg && (s1_cmd_reg == CMD_EVAL);
    assign s1_side.last  = s1_last_reg;

    // stage 1 -> 2: interval index and fraction
    ucher_locate #(
        .KNOT_DEPTH    (KNOT_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .side_in   (s1_side),
        .num_knots (num_knots_reg),
        .position  (s1_pos_reg),
        .side_out  (s2_side),
        .k_out     (s2_k),
        .t_out     (s2_t)
    );

    // stage 2 load payload
    always_ff @(posedge clk)
    begin
        s2_widx_reg  <= s1_idx_reg;
        s2_wdata_reg <= s1_word_reg;
    end

    // even bank holds knots 2j, odd bank 2j+1; k and k+1 hit one of each
    always_comb
    begin
        k_plus     = {1'b0, s2_k} + (KW + 1)'(1);
        even_raddr = BANK_AW'(k_plus >> 1);
        odd_raddr  = BANK_AW'(s2_k >> 1);
        bank_waddr = BANK_AW'(s2_widx_reg >> 1);
    end

    ucher_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (s2_we_reg && !s2_widx_reg[0]),
        .waddr (bank_waddr),
        .wdata (s2_wdata_reg),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    ucher_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (s2_we_reg && s2_widx_reg[0]),
        .waddr (bank_waddr),
        .wdata (s2_wdata_reg),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    // stage 3 payload
    always_ff @(posedge clk)
    begin
        s3_t_reg   <= s2_t;
        s3_odd_reg <= s2_k[0];
    end

    // stage 3: order the knots and form the Hermite coefficients
    always_comb
    begin
        if (s3_odd_reg)
        begin
            p0 = odd_rdata[WORD_W-1:VALUE_W];
            m0 = odd_rdata[VALUE_W-1:0];
            p1 = even_rdata[WORD_W-1:VALUE_W];
            m1 = even_rdata[VALUE_W-1:0];
        end
        else
        begin
            p0 = even_rdata[WORD_W-1:VALUE_W];
            m0 = even_rdata[VALUE_W-1:0];
            p1 = odd_rdata[WORD_W-1:VALUE_W];
            m1 = odd_rdata[VALUE_W-1:0];
        end
        p0x = COEF_W'(p0);
        m0x = COEF_W'(m0);
        p1x = COEF_W'(p1);
        m1x = COEF_W'(m1);
        // c2 = -3p0 - 2m0 + 3p1 - m1, c3 = 2p0 + m0 - 2p1 + m1
        c2_next = (p1x <<< 1) + p1x - (p0x <<< 1) - p0x - (m0x <<< 1) - m1x;
        c3_next = (p0x <<< 1) + m0x - (p1x <<< 1) + m1x;
    end

    // stage 4 payload
    always_ff @(posedge clk)
    begin
        s4_t_reg  <= s3_t_reg;
        s4_c0_reg <= p0x;
        s4_c1_reg <= m0x;
        s4_c2_reg <= c2_next;
        s4_c3_reg <= c3_next;
    end

    // Horner: c3*t + c2
    ucher_horner #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_horner_1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (s4_side_reg),
        .acc_in   (ACC_W'(s4_c3_reg)),
        .t_in     (s4_t_reg),
        .c_in     (ACC_W'(s4_c2_reg)),
        .side_out (h1_side),
        .acc_out  (h1_acc),
        .t_out    (h1_t)
    );

    // remaining coefficients ride alongside
    always_ff @(posedge clk)
    begin
        s5_c1_reg <= s4_c1_reg;
        s5_c0_reg <= s4_c0_reg;
        s6_c0_reg <= s5_c0_reg;
    end

    // Horner: acc*t + c1
    ucher_horner #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_horner_2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (h1_side),
        .acc_in   (h1_acc),
        .t_in     (h1_t),
        .c_in     (ACC_W'(s5_c1_reg)),
        .side_out (h2_side),
        .acc_out  (h2_acc),
        .t_out    (h2_t)
    );

    // Horner: acc*t + c0
    ucher_horner #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_horner_3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (h2_side),
        .acc_in   (h2_acc),
        .t_in     (h2_t),
        .c_in     (ACC_W'(s6_c0_reg)),
        .side_out (h3_side),
        .acc_out  (h3_acc),
        .t_out    (h3_t)
    );

    // saturate to 32 bits
    always_comb
    begin
        acc_wide = 64'(h3_acc);
        if (acc_wide > SAT_MAX)
        begin
            value_next = RESULT_W'(SAT_MAX);
            sat_next   = 1'b1;
        end
        else if (acc_wide < SAT_MIN)
        begin
            value_next = RESULT_W'(SAT_MIN);
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = RESULT_W'(acc_wide);
            sat_next   = 1'b0;
        end
    end

    // output payload; t of the last step is not needed
    always_ff @(posedge clk)
    begin
        spline_value_reg <= value_next;
        saturated_reg    <= sat_next;
        last_result_reg  <= h3_side.last;
    end

    assign result_valid = result_valid_reg;
    assign spline_value = spline_value_reg;
    assign saturated    = saturated_reg;
    assign last_result  = last_result_reg;

endmodule
